/* design/ntt_radix2_modular_top_macros.svh */
// Assertion macros shared by the checker of the transform block.
`ifndef NTT_RADIX2_MODULAR_TOP_MACROS_SVH
`define NTT_RADIX2_MODULAR_TOP_MACROS_SVH

// Checked only while the block is out of reset.
`define NTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define NTT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ntt_pkg.sv */
`default_nettype none
package ntt_pkg;

  localparam int DATA_W = 64;
  localparam int IDX_W  = 2;
  localparam int LG_W   = 3;

  typedef logic [DATA_W-1:0] word_t;

  localparam word_t GOLDILOCKS = 64'hFFFF_FFFF_0000_0001;
  localparam word_t ROOT_GOLD  = 64'd7;
  localparam word_t ROOT_OTHER = 64'd3;

  localparam logic [IDX_W-1:0] CFG_MODULUS = 2'd0;
  localparam logic [IDX_W-1:0] CFG_LOG2    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_INVERSE = 2'd2;

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  // Modular addition of two reduced operands; a zero modulus wraps at 2^64.
  function automatic word_t madd(input word_t a, input word_t b, input word_t m);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (m != '0 && (s[DATA_W] || s[DATA_W-1:0] >= m)) begin
      return s[DATA_W-1:0] - m;
    end
    return s[DATA_W-1:0];
  endfunction

  // Modular subtraction of two reduced operands.
  function automatic word_t msub(input word_t a, input word_t b, input word_t m);
    if (a >= b) begin
      return a - b;
    end
    return m - (b - a);
  endfunction

endpackage
`default_nettype wire

/* design/ntt_ram.sv */
`default_nettype none
module ntt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/ntt_modmul.sv */
`default_nettype none
module ntt_modmul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ntt_pkg::mul_req_t req,
  input  wire ntt_pkg::word_t    modulus,
  output logic                   done,
  output ntt_pkg::word_t         res
);

  // Double-and-add over the bits of b, most significant first. The a operand
  // must already be reduced.
  logic           busy_r;
  logic           add_ph_r;
  logic [5:0]     cnt_r;
  ntt_pkg::word_t a_r;
  ntt_pkg::word_t b_r;
  ntt_pkg::word_t m_r;
  ntt_pkg::word_t r_r;
  logic           done_r;

  assign done = done_r;
  assign res  = r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      add_ph_r <= 1'b0;
      cnt_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r   <= 1'b1;
        add_ph_r <= 1'b0;
        cnt_r    <= '0;
        a_r      <= req.a;
        b_r      <= req.b;
        m_r      <= modulus;
        r_r      <= '0;
      end else if (busy_r) begin
        if (!add_ph_r) begin
          r_r <= ntt_pkg::madd(r_r, r_r, m_r);
          if (b_r[ntt_pkg::DATA_W-1]) begin
            add_ph_r <= 1'b1;
          end else begin
            b_r   <= b_r << 1;
            cnt_r <= cnt_r + 6'd1;
            if (&cnt_r) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end else begin
          r_r      <= ntt_pkg::madd(r_r, a_r, m_r);
          add_ph_r <= 1'b0;
          b_r      <= b_r << 1;
          cnt_r    <= cnt_r + 6'd1;
          if (&cnt_r) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* design/ntt_radix2_modular_top.sv */
// Channel  | Direction | Signals
// input    | in        | in_valid, in_ready, in_coefficient
// result   | out       | out_valid, out_ready, out_value, out_final_res
// config   | in        | cfg_we, cfg_index, cfg_data
// The last coefficient of a block starts the transform.
// Every modular multiply runs on one shared bit-serial unit.
// A 64-point forward transform needs about 600 multiplies plus powers for the root
// and the stage twiddles; an inverse one adds powers for the inverse root and scale.
// Reset is synchronous and active low and drops any partly loaded block.
// The block takes a new coefficient while the last result still waits for out_ready.
`default_nettype none
module ntt_radix2_modular_top #(
  parameter int MAX_N = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [63:0]                in_coefficient,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [63:0]                out_value,
  output logic                            out_final_res,
  input  wire logic                       cfg_we,
  input  wire logic [ntt_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                cfg_data
);

  localparam int AW     = $clog2(MAX_N);
  localparam int CW     = AW + 1;
  localparam int LG_MAX = $clog2(MAX_N + 1) - 1;

  typedef enum logic [5:0] {
    ST_LOAD, ST_MWAIT,
    ST_POW_START, ST_POW_BASE, ST_POW_LOOP, ST_POW_MUL, ST_POW_SQ, ST_POW_SQD,
    ST_ROOT, ST_ROOT_DONE, ST_RINV_DONE,
    ST_PERM_CHK, ST_PERM_R1, ST_PERM_R2, ST_PERM_W, ST_PERM_NX,
    ST_STG_INIT, ST_STG_TW,
    ST_BF_RD, ST_BF_R1, ST_BF_R2, ST_BF_U, ST_BF_FT, ST_BF_FW, ST_BF_IV, ST_BF_IW,
    ST_BF_NX,
    ST_SC_INIT, ST_SC_TW, ST_SC_RD, ST_SC_R1, ST_SC_W,
    ST_EM_RD, ST_EM_WR
  } state_t;

  state_t state_r, mret_r, pret_r;

  ntt_pkg::word_t              mod_r;
  logic [ntt_pkg::LG_W-1:0]    lg_cfg_r;
  logic                        inv_r;
  logic [AW-1:0]               load_cnt_r;
  logic [AW-1:0]               i_r;
  logic [AW-1:0]               b_r;
  logic [ntt_pkg::LG_W-1:0]    s_r;
  ntt_pkg::word_t              root_r, st_r, rt_r, scale_r, u_r, v_r;
  ntt_pkg::word_t              pw_base_r, pw_exp_r, pw_res_r;
  logic                        pw_used_r;
  ntt_pkg::mul_req_t           mul_req_r;
  logic                        out_valid_r;
  ntt_pkg::word_t              out_value_r;
  logic                        out_final_r;

  logic                        mul_done;
  ntt_pkg::word_t              mul_res;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  ntt_pkg::word_t              ram_wdata, ram_rdata;

  logic [ntt_pkg::LG_W-1:0]    lg_eff;
  logic [CW-1:0]               n_w;
  ntt_pkg::word_t              one_red;
  logic [AW-1:0]               rev_i, h_w, lowm, idx0, idx1;
  logic                        last_i, last_b, in_acc;
  logic                        cfg_clr;

  function automatic logic [AW-1:0] rev_idx(input logic [AW-1:0] x,
                                            input logic [ntt_pkg::LG_W-1:0] lg);
    logic [AW-1:0] r;
    r = '0;
    for (int k = 0; k < AW; k++) begin
      if (k < int'(lg)) r[int'(lg) - 1 - k] = x[k];
    end
    return r;
  endfunction

  always_comb begin
    if (int'(lg_cfg_r) > LG_MAX) lg_eff = ntt_pkg::LG_W'(LG_MAX);
    else lg_eff = lg_cfg_r;
  end

  assign n_w     = CW'(1) << lg_eff;
  assign one_red = (mod_r == 64'd1) ? 64'd0 : 64'd1;
  assign rev_i   = rev_idx(i_r, lg_eff);
  assign h_w     = AW'(1) << s_r;
  assign lowm    = h_w - AW'(1);
  assign idx0    = ((b_r & ~lowm) << 1) | (b_r & lowm);
  assign idx1    = idx0 | h_w;
  assign last_i  = ({1'b0, i_r} == n_w - CW'(1));
  assign last_b  = ({1'b0, b_r} == (n_w >> 1) - CW'(1));
  assign in_ready = (state_r == ST_LOAD);
  assign in_acc  = in_valid && in_ready;
  assign cfg_clr = cfg_we && (cfg_index inside {ntt_pkg::CFG_MODULUS, ntt_pkg::CFG_LOG2,
                                                ntt_pkg::CFG_INVERSE});

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_final_res = out_final_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      ST_LOAD: begin
        ram_we    = in_acc;
        ram_waddr = load_cnt_r;
        ram_wdata = in_coefficient;
      end
      ST_PERM_CHK: begin
        ram_re    = (i_r < rev_i);
        ram_raddr = i_r;
      end
      ST_PERM_R1: begin
        ram_re    = 1'b1;
        ram_raddr = rev_i;
      end
      ST_PERM_R2: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = ram_rdata;
      end
      ST_PERM_W: begin
        ram_we    = 1'b1;
        ram_waddr = rev_i;
        ram_wdata = u_r;
      end
      ST_BF_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx0;
      end
      ST_BF_R1: begin
        ram_re    = 1'b1;
        ram_raddr = idx1;
      end
      ST_BF_FT, ST_BF_IV: begin
        ram_we    = 1'b1;
        ram_waddr = idx0;
        ram_wdata = ntt_pkg::madd(u_r, mul_res, mod_r);
      end
      ST_BF_FW: begin
        ram_we    = 1'b1;
        ram_waddr = idx1;
        ram_wdata = v_r;
      end
      ST_BF_IW: begin
        ram_we    = 1'b1;
        ram_waddr = idx1;
        ram_wdata = mul_res;
      end
      ST_SC_RD, ST_EM_RD: begin
        ram_re    = 1'b1;
        ram_raddr = i_r;
      end
      ST_SC_W: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = mul_res;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_LOAD;
      mret_r          <= ST_LOAD;
      pret_r          <= ST_LOAD;
      mod_r           <= ntt_pkg::GOLDILOCKS;
      lg_cfg_r        <= 3'd6;
      inv_r           <= 1'b0;
      load_cnt_r      <= '0;
      mul_req_r.start <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_ready && state_r != ST_EM_WR) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          ntt_pkg::CFG_MODULUS: begin
            mod_r <= cfg_data;
          end
          ntt_pkg::CFG_LOG2: begin
            lg_cfg_r <= cfg_data[ntt_pkg::LG_W-1:0];
          end
          ntt_pkg::CFG_INVERSE: begin
            inv_r <= cfg_data[0];
          end
          default: begin
            mod_r <= mod_r;
          end
        endcase
      end
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if ({1'b0, load_cnt_r} == n_w - CW'(1)) begin
              load_cnt_r <= '0;
              state_r    <= ST_ROOT;
            end else begin
              load_cnt_r <= cfg_clr ? '0 : load_cnt_r + AW'(1);
            end
          end else if (cfg_clr) begin
            load_cnt_r <= '0;
          end
        end
        ST_MWAIT: begin
          mul_req_r.start <= 1'b0;
          if (mul_done) state_r <= mret_r;
        end
        ST_POW_START: begin
          mul_req_r <= '{start: 1'b1, a: one_red, b: pw_base_r};
          mret_r    <= ST_POW_BASE;
          state_r   <= ST_MWAIT;
        end
        ST_POW_BASE: begin
          pw_base_r <= mul_res;
          pw_res_r  <= one_red;
          pw_used_r <= 1'b0;
          state_r   <= ST_POW_LOOP;
        end
        ST_POW_LOOP: begin
          if (pw_exp_r == '0) begin
            if (!pw_used_r) pw_res_r <= 64'd1;
            state_r <= pret_r;
          end else if (pw_exp_r[0]) begin
            mul_req_r <= '{start: 1'b1, a: pw_res_r, b: pw_base_r};
            mret_r    <= ST_POW_MUL;
            state_r   <= ST_MWAIT;
          end else begin
            state_r <= ST_POW_SQ;
          end
        end
        ST_POW_MUL: begin
          pw_res_r  <= mul_res;
          pw_used_r <= 1'b1;
          state_r   <= ST_POW_SQ;
        end
        ST_POW_SQ: begin
          pw_exp_r <= pw_exp_r >> 1;
          if (pw_exp_r[63:1] == '0) begin
            state_r <= ST_POW_LOOP;
          end else begin
            mul_req_r <= '{start: 1'b1, a: pw_base_r, b: pw_base_r};
            mret_r    <= ST_POW_SQD;
            state_r   <= ST_MWAIT;
          end
        end
        ST_POW_SQD: begin
          pw_base_r <= mul_res;
          state_r   <= ST_POW_LOOP;
        end
        ST_ROOT: begin
          pw_base_r <= (mod_r == ntt_pkg::GOLDILOCKS) ? ntt_pkg::ROOT_GOLD
                                                       : ntt_pkg::ROOT_OTHER;
          pw_exp_r  <= (mod_r - 64'd1) >> lg_eff;
          pret_r    <= ST_ROOT_DONE;
          state_r   <= ST_POW_START;
        end
        ST_ROOT_DONE: begin
          root_r <= pw_res_r;
          if (inv_r) begin
            pw_base_r <= pw_res_r;
            pw_exp_r  <= mod_r - 64'd2;
            pret_r    <= ST_RINV_DONE;
            state_r   <= ST_POW_START;
          end else begin
            i_r     <= '0;
            state_r <= ST_PERM_CHK;
          end
        end
        ST_RINV_DONE: begin
          root_r <= pw_res_r;
          if (lg_eff == '0) begin
            i_r     <= '0;
            state_r <= ST_PERM_CHK;
          end else begin
            s_r     <= lg_eff - 3'd1;
            state_r <= ST_STG_INIT;
          end
        end
        ST_PERM_CHK: begin
          state_r <= (i_r < rev_i) ? ST_PERM_R1 : ST_PERM_NX;
        end
        ST_PERM_R1: begin
          u_r     <= ram_rdata;
          state_r <= ST_PERM_R2;
        end
        ST_PERM_R2: begin
          state_r <= ST_PERM_W;
        end
        ST_PERM_W: begin
          state_r <= ST_PERM_NX;
        end
        ST_PERM_NX: begin
          if (last_i) begin
            if (inv_r) begin
              state_r <= ST_SC_INIT;
            end else if (lg_eff == '0) begin
              i_r     <= '0;
              state_r <= ST_EM_RD;
            end else begin
              s_r     <= '0;
              state_r <= ST_STG_INIT;
            end
          end else begin
            i_r     <= i_r + AW'(1);
            state_r <= ST_PERM_CHK;
          end
        end
        ST_STG_INIT: begin
          pw_base_r <= root_r;
          pw_exp_r  <= 64'd1 << (lg_eff - s_r - 3'd1);
          pret_r    <= ST_STG_TW;
          state_r   <= ST_POW_START;
        end
        ST_STG_TW: begin
          st_r    <= pw_res_r;
          b_r     <= '0;
          state_r <= ST_BF_RD;
        end
        ST_BF_RD: begin
          if ((b_r & lowm) == '0) rt_r <= one_red;
          state_r <= ST_BF_R1;
        end
        ST_BF_R1: begin
          u_r     <= ram_rdata;
          state_r <= ST_BF_R2;
        end
        ST_BF_R2: begin
          v_r       <= ram_rdata;
          mul_req_r <= '{start: 1'b1, a: one_red, b: u_r};
          mret_r    <= ST_BF_U;
          state_r   <= ST_MWAIT;
        end
        ST_BF_U: begin
          u_r <= mul_res;
          if (!inv_r) begin
            mul_req_r <= '{start: 1'b1, a: rt_r, b: v_r};
            mret_r    <= ST_BF_FT;
          end else begin
            mul_req_r <= '{start: 1'b1, a: one_red, b: v_r};
            mret_r    <= ST_BF_IV;
          end
          state_r <= ST_MWAIT;
        end
        ST_BF_FT: begin
          v_r     <= ntt_pkg::msub(u_r, mul_res, mod_r);
          state_r <= ST_BF_FW;
        end
        ST_BF_FW: begin
          mul_req_r <= '{start: 1'b1, a: rt_r, b: st_r};
          mret_r    <= ST_BF_NX;
          state_r   <= ST_MWAIT;
        end
        ST_BF_IV: begin
          mul_req_r <= '{start: 1'b1, a: ntt_pkg::msub(u_r, mul_res, mod_r), b: rt_r};
          mret_r    <= ST_BF_IW;
          state_r   <= ST_MWAIT;
        end
        ST_BF_IW: begin
          mul_req_r <= '{start: 1'b1, a: rt_r, b: st_r};
          mret_r    <= ST_BF_NX;
          state_r   <= ST_MWAIT;
        end
        ST_BF_NX: begin
          rt_r <= mul_res;
          if (!last_b) begin
            b_r     <= b_r + AW'(1);
            state_r <= ST_BF_RD;
          end else if (!inv_r) begin
            if (s_r == lg_eff - 3'd1) begin
              i_r     <= '0;
              state_r <= ST_EM_RD;
            end else begin
              s_r     <= s_r + 3'd1;
              state_r <= ST_STG_INIT;
            end
          end else begin
            if (s_r == '0) begin
              i_r     <= '0;
              state_r <= ST_PERM_CHK;
            end else begin
              s_r     <= s_r - 3'd1;
              state_r <= ST_STG_INIT;
            end
          end
        end
        ST_SC_INIT: begin
          pw_base_r <= 64'(n_w);
          pw_exp_r  <= mod_r - 64'd2;
          pret_r    <= ST_SC_TW;
          state_r   <= ST_POW_START;
        end
        ST_SC_TW: begin
          scale_r <= pw_res_r;
          i_r     <= '0;
          state_r <= ST_SC_RD;
        end
        ST_SC_RD: begin
          state_r <= ST_SC_R1;
        end
        ST_SC_R1: begin
          mul_req_r <= '{start: 1'b1, a: scale_r, b: ram_rdata};
          mret_r    <= ST_SC_W;
          state_r   <= ST_MWAIT;
        end
        ST_SC_W: begin
          if (last_i) begin
            i_r     <= '0;
            state_r <= ST_EM_RD;
          end else begin
            i_r     <= i_r + AW'(1);
            state_r <= ST_SC_RD;
          end
        end
        ST_EM_RD: begin
          state_r <= ST_EM_WR;
        end
        ST_EM_WR: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_value_r <= ram_rdata;
            out_final_r <= last_i;
            if (last_i) begin
              state_r <= ST_LOAD;
            end else begin
              i_r     <= i_r + AW'(1);
              state_r <= ST_EM_RD;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  ntt_ram #(
    .WIDTH(ntt_pkg::DATA_W),
    .DEPTH(MAX_N)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ntt_modmul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req_r),
    .modulus (mod_r),
    .done    (mul_done),
    .res     (mul_res)
  );

endmodule
`default_nettype wire

/* design/ntt_chk.sv */
`default_nettype none
`include "ntt_radix2_modular_top_macros.svh"
module ntt_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_value,
  input wire logic        out_final_res
);

  `NTT_ASSERT_RST(a_rst_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `NTT_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid, "stalled result dropped")
  `NTT_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_value) && $stable(out_final_res), "stalled result changed")
  `NTT_ASSERT(a_no_load_mid_burst, out_valid && !out_final_res |-> !in_ready, "input taken during result burst")

endmodule

bind ntt_radix2_modular_top ntt_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_value     (out_value),
  .out_final_res (out_final_res)
);
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_IDLE = 500000;
  localparam int MAX_PTS = 64;

  typedef enum logic {ROW_CFG, ROW_COEF} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    logic [ntt_pkg::IDX_W-1:0] idx;
    ntt_pkg::word_t            data;
    int                        n_typed;
    ntt_pkg::word_t            t0;
    ntt_pkg::word_t            t1;
  } row_t;

  typedef struct {
    ntt_pkg::word_t value;
    logic           last;
  } spec_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [63:0]               in_coefficient;
  logic                      out_valid;
  logic                      out_ready;
  logic [63:0]               out_value;
  logic                      out_final_res;
  logic                      cfg_we;
  logic [ntt_pkg::IDX_W-1:0] cfg_index;
  logic [63:0]               cfg_data;

  ntt_radix2_modular_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_coefficient(in_coefficient),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_final_res(out_final_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  ntt_pkg::word_t coeffs [MAX_PTS];
  int             loaded;
  ntt_pkg::word_t mod_r;
  logic [2:0]     lg_r;
  logic           inv_r;
  spec_t          spectrum_q [$];
  spec_t          fresh_q [$];

  int       mismatches;
  int       results_seen;
  int       idle_cycles;
  int       blocks_done;
  int       items_sent;
  bit       hold_req;
  bit       hold_done;
  row_t     plan [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic ntt_pkg::word_t m_red(ntt_pkg::word_t x, ntt_pkg::word_t m);
    return (m != '0) ? x % m : x;
  endfunction

  function automatic ntt_pkg::word_t m_add(ntt_pkg::word_t a, ntt_pkg::word_t b,
                                           ntt_pkg::word_t m);
    logic [64:0] s;
    a = m_red(a, m);
    b = m_red(b, m);
    s = {1'b0, a} + {1'b0, b};
    if (m != '0 && (s[64] || s[63:0] >= m)) s = s - {1'b0, m};
    return s[63:0];
  endfunction

  function automatic ntt_pkg::word_t m_sub(ntt_pkg::word_t a, ntt_pkg::word_t b,
                                           ntt_pkg::word_t m);
    a = m_red(a, m);
    b = m_red(b, m);
    return (a >= b) ? a - b : m - (b - a);
  endfunction

  function automatic ntt_pkg::word_t m_mul(ntt_pkg::word_t a, ntt_pkg::word_t b,
                                           ntt_pkg::word_t m);
    logic [127:0] p;
    if (m == '0) return a * b;
    p = {64'd0, a} * {64'd0, b};
    p = p % {64'd0, m};
    return p[63:0];
  endfunction

  function automatic ntt_pkg::word_t m_pow(ntt_pkg::word_t base, ntt_pkg::word_t e,
                                           ntt_pkg::word_t m);
    ntt_pkg::word_t r;
    r = 64'd1;
    base = m_red(base, m);
    while (e != '0) begin
      if (e[0]) r = m_mul(r, base, m);
      e = e >> 1;
      base = m_mul(base, base, m);
    end
    return r;
  endfunction

  function automatic int rev_index(int x, int lg);
    int r;
    r = 0;
    for (int k = 0; k < lg; k++) r |= ((x >> k) & 1) << (lg - 1 - k);
    return r;
  endfunction

  function automatic void swap_bitrev(int n, int lg);
    int j;
    ntt_pkg::word_t t;
    for (int i = 0; i < n; i++) begin
      j = rev_index(i, lg);
      if (i < j) begin
        t = coeffs[i];
        coeffs[i] = coeffs[j];
        coeffs[j] = t;
      end
    end
  endfunction

  function automatic void run_ntt(int n, int lg);
    ntt_pkg::word_t m, g, root, rinv, stw, rtw, u, v, t, sc;
    int h;
    m = mod_r;
    g = (m == ntt_pkg::GOLDILOCKS) ? ntt_pkg::ROOT_GOLD : ntt_pkg::ROOT_OTHER;
    root = m_pow(g, (m - 64'd1) >> lg, m);
    if (!inv_r) begin
      swap_bitrev(n, lg);
      for (int len = 2; len <= n; len = len << 1) begin
        h = len >> 1;
        stw = m_pow(root, n / len, m);
        for (int i = 0; i < n; i += len) begin
          rtw = 64'd1;
          for (int j = 0; j < h; j++) begin
            u = coeffs[i+j];
            t = m_mul(rtw, coeffs[i+j+h], m);
            coeffs[i+j] = m_add(u, t, m);
            coeffs[i+j+h] = m_sub(u, t, m);
            rtw = m_mul(rtw, stw, m);
          end
        end
      end
    end else begin
      rinv = m_pow(root, m - 64'd2, m);
      for (int len = n; len >= 2; len = len >> 1) begin
        h = len >> 1;
        stw = m_pow(rinv, n / len, m);
        for (int i = 0; i < n; i += len) begin
          rtw = 64'd1;
          for (int j = 0; j < h; j++) begin
            u = coeffs[i+j];
            v = coeffs[i+j+h];
            coeffs[i+j] = m_add(u, v, m);
            coeffs[i+j+h] = m_mul(m_sub(u, v, m), rtw, m);
            rtw = m_mul(rtw, stw, m);
          end
        end
      end
      swap_bitrev(n, lg);
      sc = m_pow(ntt_pkg::word_t'(n), m - 64'd2, m);
      for (int i = 0; i < n; i++) coeffs[i] = m_mul(coeffs[i], sc, m);
    end
  endfunction

  // Loads one coefficient; a completed block leaves its spectrum in fresh_q.
  function automatic void absorb_coeff(ntt_pkg::word_t c);
    int lg, n;
    fresh_q.delete();
    lg = lg_r;
    if (lg > 6) lg = 6;
    n = 1 << lg;
    if (loaded < MAX_PTS) coeffs[loaded] = c;
    loaded++;
    if (loaded >= n) begin
      loaded = 0;
      run_ntt(n, lg);
      for (int i = 0; i < n; i++) fresh_q.push_back('{coeffs[i], i == n - 1});
    end
  endfunction

  function automatic void add_row(row_kind_t k, logic [ntt_pkg::IDX_W-1:0] idx,
                                  ntt_pkg::word_t d, int nt = 0,
                                  ntt_pkg::word_t t0 = 0, ntt_pkg::word_t t1 = 0);
    plan.push_back('{k, idx, d, nt, t0, t1});
  endfunction

  task automatic wait_idle();
    while (spectrum_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [ntt_pkg::IDX_W-1:0] idx, ntt_pkg::word_t d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    idle_cycles = 0;
    case (idx)
      ntt_pkg::CFG_MODULUS: begin mod_r = d; loaded = 0; end
      ntt_pkg::CFG_LOG2:    begin lg_r = d[2:0]; loaded = 0; end
      ntt_pkg::CFG_INVERSE: begin inv_r = d[0]; loaded = 0; end
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_coeff(ntt_pkg::word_t c, int nt = 0, ntt_pkg::word_t t0 = 0,
                            ntt_pkg::word_t t1 = 0);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_coefficient = c;
    do @(posedge clk); while (!in_ready);
    absorb_coeff(c);
    if (nt > 0 && fresh_q.size() > 0) fresh_q[0].value = t0;
    if (nt > 1 && fresh_q.size() > 1) fresh_q[1].value = t1;
    foreach (fresh_q[i]) spectrum_q.push_back(fresh_q[i]);
    if (fresh_q.size() > 0) blocks_done++;
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic ntt_pkg::word_t pick_coeff(ntt_pkg::word_t m);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return {$urandom, $urandom};
    if (r < 80) return (m > 64'd1) ? m_red({$urandom, $urandom}, m) : 64'd0;
    case ($urandom_range(0, 2))
      0: return 64'd0;
      1: return m - 64'd1;
      default: return '1;
    endcase
  endfunction

  function automatic ntt_pkg::word_t pick_modulus();
    int r;
    ntt_pkg::word_t small_p [7];
    ntt_pkg::word_t big_p [4];
    small_p = '{64'd17, 64'd97, 64'd257, 64'd7681, 64'd12289, 64'd65537, 64'd3};
    big_p = '{ntt_pkg::GOLDILOCKS, 64'hFFFF_FFFF_FFFF_FFC5, 64'h1FFF_FFFF_FFFF_FFFF,
              64'h0000_0000_FFFF_FFFB};
    r = $urandom_range(0, 99);
    if (r < 82) return small_p[$urandom_range(0, 6)];
    if (r < 93) return big_p[$urandom_range(0, 3)];
    return ntt_pkg::word_t'($urandom_range(0, 1));
  endfunction

  // Result checking.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      idle_cycles <= 0;
      results_seen++;
      if (spectrum_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result value=%h final=%b", out_value,
                                       out_final_res);
      end else begin
        if (out_value !== spectrum_q[0].value || out_final_res !== spectrum_q[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value=%h final=%b, got value=%h final=%b",
                     spectrum_q[0].value, spectrum_q[0].last, out_value, out_final_res);
        end
        void'(spectrum_q.pop_front());
      end
    end else if (rst_n && in_valid && in_ready) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= LIMIT_IDLE) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver with random stalls and one long hold-off.
  initial begin
    int r;
    bit calm;
    calm = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 1'b0;
        repeat (3000) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if ($urandom_range(0, 49) == 0) calm = ~calm;
        r = $urandom_range(0, 99);
        if (calm || r < 70) begin
          out_ready = 1'b1;
        end else begin
          out_ready = 1'b0;
          repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk);
        end
      end
    end
  end

  initial begin
    ntt_pkg::word_t m;
    int lg, reps, n, rand_items;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_coefficient = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    idle_cycles = 0;
    blocks_done = 0;
    items_sent = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    loaded = 0;
    mod_r = ntt_pkg::GOLDILOCKS;
    lg_r = 3'd6;
    inv_r = 1'b0;
    foreach (coeffs[i]) coeffs[i] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The settings after reset: a full 64-point forward transform.
    for (int i = 0; i < 64; i++) send_coeff(pick_coeff(ntt_pkg::GOLDILOCKS));

    // Directed part.
    add_row(ROW_CFG, ntt_pkg::CFG_LOG2, 64'd0);
    add_row(ROW_COEF, 0, '1, 1, '1);
    add_row(ROW_COEF, 0, 64'd0, 1, 64'd0);
    add_row(ROW_CFG, ntt_pkg::CFG_INVERSE, 64'd1);
    add_row(ROW_COEF, 0, '1, 1, 64'hFFFF_FFFE);
    add_row(ROW_CFG, ntt_pkg::CFG_MODULUS, 64'd1);
    add_row(ROW_COEF, 0, 64'd12345, 1, 64'd0);
    add_row(ROW_CFG, ntt_pkg::CFG_MODULUS, 64'd0);
    add_row(ROW_CFG, ntt_pkg::CFG_INVERSE, 64'd0);
    add_row(ROW_CFG, ntt_pkg::CFG_LOG2, 64'd1);
    add_row(ROW_COEF, 0, 64'd5);
    add_row(ROW_COEF, 0, 64'd7, 2, 64'd12, 64'hFFFF_FFFF_FFFF_FFFE);
    add_row(ROW_CFG, ntt_pkg::CFG_MODULUS, 64'd17);
    add_row(ROW_CFG, ntt_pkg::CFG_LOG2, 64'd2);
    add_row(ROW_COEF, 0, 64'd1);
    add_row(ROW_COEF, 0, 64'd2);
    add_row(ROW_COEF, 0, 64'd3);
    add_row(ROW_CFG, ntt_pkg::CFG_LOG2, 64'd2);
    add_row(ROW_COEF, 0, 64'd16);
    add_row(ROW_COEF, 0, 64'd20);
    add_row(ROW_COEF, 0, 64'd0);
    add_row(ROW_COEF, 0, 64'd5);
    add_row(ROW_COEF, 0, 64'd3);
    add_row(ROW_CFG, 2'd3, '1);
    add_row(ROW_COEF, 0, 64'd4);
    add_row(ROW_COEF, 0, 64'd5);
    add_row(ROW_COEF, 0, 64'd6);
    add_row(ROW_CFG, ntt_pkg::CFG_MODULUS, 64'hFFFF_FFFF_FFFF_FFC5);
    add_row(ROW_CFG, ntt_pkg::CFG_LOG2, 64'd3);
    add_row(ROW_CFG, ntt_pkg::CFG_INVERSE, 64'd1);
    for (int i = 0; i < 8; i++) add_row(ROW_COEF, 0, '1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_coeff(plan[i].data, plan[i].n_typed, plan[i].t0, plan[i].t1);
      end
    end

    // Random part; the receiver holds off once early on.
    hold_req = 1'b1;
    rand_items = 0;
    while (rand_items < 20) begin
      m = pick_modulus();
      lg = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
      wait_idle();
      write_reg(ntt_pkg::CFG_MODULUS, m);
      write_reg(ntt_pkg::CFG_LOG2, ntt_pkg::word_t'(lg) | ({$urandom, $urandom} & ~64'h7));
      write_reg(ntt_pkg::CFG_INVERSE,
                ntt_pkg::word_t'($urandom_range(0, 1)) | ({$urandom, $urandom} & ~64'h1));
      n = 1 << lg;
      reps = $urandom_range(1, 3);
      for (int b = 0; b < reps; b++) begin
        for (int i = 0; i < n; i++) begin
          send_coeff(pick_coeff(m));
          rand_items++;
        end
      end
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < $urandom_range(1, n); i++) begin
          if (n > 1) send_coeff(pick_coeff(m));
        end
      end
    end

    // Oversized length falls back to 64 points, inverse on the Goldilocks prime.
    wait_idle();
    write_reg(ntt_pkg::CFG_MODULUS, ntt_pkg::GOLDILOCKS);
    write_reg(ntt_pkg::CFG_LOG2, 64'd7);
    write_reg(ntt_pkg::CFG_INVERSE, 64'd1);
    for (int i = 0; i < 64; i++) send_coeff(pick_coeff(ntt_pkg::GOLDILOCKS));
    in_valid = 1'b0;

    while (spectrum_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("Sent %0d coefficients forming %0d transforms; %0d results compared.",
             items_sent, blocks_done, results_seen);
    $display("Sizes 1 to 64, forward and inverse, several moduli, long output stall.");
    if (mismatches == 0 && spectrum_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/ntt_pkg.sv
design/ntt_ram.sv
design/ntt_modmul.sv
design/ntt_radix2_modular_top.sv
design/ntt_chk.sv
dv/tb.sv
